[src/erm_pkg.sv]
// Package for the Euler-angle to rotation-matrix block.
// Holds widths, request/result types, CORDIC constants and fixed-point helpers.
// No dependencies.
`default_nettype none
package erm_pkg;

	localparam int ANGLE_BITS    = 16;
	localparam int ELEMENT_BITS  = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int ANGLE_FRAC    = ANGLE_BITS - 4;
	localparam int ELEM_FRAC     = ELEMENT_BITS - 2;

	// angle in Q.32, and one more bit for the wrap add
	localparam int ANG_W = ANGLE_BITS + 32 - ANGLE_FRAC;
	localparam int RED_W = ANG_W + 1;
	// CORDIC working width (Q.32, magnitude below 2^33)
	localparam int CW = 36;
	// sine/cosine and products in Q.30
	localparam int QW = 32;

	typedef struct packed {
		logic signed [ANGLE_BITS-1:0] angle_x;
		logic signed [ANGLE_BITS-1:0] angle_y;
		logic signed [ANGLE_BITS-1:0] angle_z;
	} req_t;

	typedef struct packed {
		logic signed [ELEMENT_BITS-1:0] elem0;
		logic signed [ELEMENT_BITS-1:0] elem1;
		logic signed [ELEMENT_BITS-1:0] elem2;
		logic signed [ELEMENT_BITS-1:0] elem3;
		logic signed [ELEMENT_BITS-1:0] elem4;
		logic signed [ELEMENT_BITS-1:0] elem5;
		logic signed [ELEMENT_BITS-1:0] elem6;
		logic signed [ELEMENT_BITS-1:0] elem7;
		logic signed [ELEMENT_BITS-1:0] elem8;
	} res_t;

	// sine and cosine of one angle, Q.30
	typedef struct packed {
		logic signed [QW-1:0] cosv;
		logic signed [QW-1:0] sinv;
	} sc_t;

	localparam logic signed [63:0] PI_Q60 = 64'sh3243F6A8885A308D;

	// round half up from Q.60 to Q.32
	function automatic logic signed [63:0] q60_to_q32(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = v + (64'sd1 <<< 27);
		return t >>> 28;
	endfunction

	// shift-subtract unsigned divide, elaboration use only
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r    = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// atan(2^-i) in Q.32 from the Taylor series in Q.60
	function automatic logic signed [63:0] atan_q32(input int i);
		logic signed [63:0] sum;
		logic [63:0] p;
		logic [63:0] term;
		sum = '0;
		if (i == 0) begin
			return q60_to_q32(PI_Q60 >>> 2);
		end
		for (int k = 0; k < 31; k++) begin
			if (i * (2 * k + 1) <= 60) begin
				p    = 64'd1 << (60 - i * (2 * k + 1));
				term = udiv64(p, 64'(2 * k + 1));
				if (k % 2 == 1) sum = sum - signed'(term);
				else            sum = sum + signed'(term);
			end
		end
		return q60_to_q32(sum);
	endfunction

	// CORDIC gain 1/prod(sqrt(1+2^-2i)), truncated Q.32
	function automatic logic signed [63:0] gain_q32();
		logic [63:0] p;
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] bitv;
		p = 64'd1 << 60;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			p = p + (p >> (2 * i));
		end
		v    = p;
		r    = '0;
		bitv = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (bitv > v) bitv = bitv >> 2;
		end
		for (int j = 0; j < 32; j++) begin
			if (bitv != 0) begin
				if (v >= r + bitv) begin
					v = v - (r + bitv);
					r = (r >> 1) + bitv;
				end else begin
					r = r >> 1;
				end
				bitv = bitv >> 2;
			end
		end
		if (r == 0) r = 64'd1;
		return signed'(udiv64(64'd1 << 62, r));
	endfunction

	localparam logic signed [63:0] PI_Q32   = q60_to_q32(PI_Q60);
	localparam logic signed [63:0] HALF_Q32 = q60_to_q32(PI_Q60 >>> 1);
	localparam logic signed [63:0] GAIN_Q32 = gain_q32();

	// Q.30 product, rounded half up
	function automatic logic signed [QW-1:0] mul30(input logic signed [QW-1:0] a,
		input logic signed [QW-1:0] b);
		logic signed [2*QW-1:0] p;
		p = a * b;
		p = p + (64'sd1 <<< 29);
		return QW'(p >>> 30);
	endfunction

	// Q.30 sum to element format, rounded half up and saturated to +-1
	function automatic logic signed [ELEMENT_BITS-1:0] to_elem(
		input logic signed [QW:0] v);
		logic signed [QW+1:0] t;
		t = (QW+2)'(v) + (QW+2)'(64'sd1 <<< (30 - ELEM_FRAC - 1));
		t = t >>> (30 - ELEM_FRAC);
		if (t > (QW+2)'(64'sd1 <<< ELEM_FRAC))       t = (QW+2)'(64'sd1 <<< ELEM_FRAC);
		else if (t < -(QW+2)'(64'sd1 <<< ELEM_FRAC)) t = -(QW+2)'(64'sd1 <<< ELEM_FRAC);
		return ELEMENT_BITS'(t);
	endfunction

endpackage
`default_nettype wire

[src/erm_cordic.sv]
// Pipelined sine/cosine unit: angle wrap, quadrant fold, rotation-mode CORDIC.
// Depends on erm_pkg.
`default_nettype none
module erm_cordic (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            vld_in,
	input  wire logic signed [erm_pkg::ANGLE_BITS-1:0] angle,
	output logic                                 vld_out,
	output erm_pkg::sc_t                         sc
);
	import erm_pkg::*;

	localparam int N = CORDIC_STAGES;

	logic                 vld_s1, vld_s2;
	logic signed [CW-1:0] a_s1;
	logic signed [CW-1:0] x_s [N+1];
	logic signed [CW-1:0] y_s [N+1];
	logic signed [CW-1:0] z_s [N+1];
	logic                 neg_s [N+1];
	logic                 vld_s [N+1];

	logic signed [RED_W-1:0] a_in;
	logic signed [RED_W-1:0] a_wrap;
	logic signed [CW-1:0]    a_fold;
	logic                    fold;

	// bring the angle into (-pi, pi]
	always_comb begin
		a_in = RED_W'(angle) <<< (32 - ANGLE_FRAC);
		if (a_in > RED_W'(PI_Q32))        a_wrap = a_in - RED_W'(2 * PI_Q32);
		else if (a_in <= -RED_W'(PI_Q32)) a_wrap = a_in + RED_W'(2 * PI_Q32);
		else                              a_wrap = a_in;
	end

	// fold into [-pi/2, pi/2], remember the sign flip
	always_comb begin
		if (a_s1 > CW'(HALF_Q32)) begin
			a_fold = a_s1 - CW'(PI_Q32);
			fold   = 1'b1;
		end else if (a_s1 < -CW'(HALF_Q32)) begin
			a_fold = a_s1 + CW'(PI_Q32);
			fold   = 1'b1;
		end else begin
			a_fold = a_s1;
			fold   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= CW'(a_wrap);
	end

	// stage 0 of the rotation chain holds the start vector
	always_ff @(posedge clk) begin
		x_s[0]   <= CW'(GAIN_Q32);
		y_s[0]   <= '0;
		z_s[0]   <= a_fold;
		neg_s[0] <= fold;
	end
	assign vld_s[0] = vld_s2;

	// one micro-rotation per stage
	for (genvar i = 0; i < N; i++) begin : g_rot
		localparam logic signed [CW-1:0] ATAN_I = CW'(atan_q32(i));
		logic r_vld_q;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) r_vld_q <= 1'b0;
			else         r_vld_q <= vld_s[i];
		end
		assign vld_s[i+1] = r_vld_q;
		always_ff @(posedge clk) begin
			if (z_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - ATAN_I;
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + ATAN_I;
			end
			neg_s[i+1] <= neg_s[i];
		end
	end

	// unfold, round to Q.30 and saturate
	function automatic logic signed [QW-1:0] to_q30(input logic signed [CW-1:0] v,
		input logic ng);
		logic signed [CW:0] t;
		t = ng ? -(CW+1)'(v) : (CW+1)'(v);
		t = (t + (CW+1)'(2)) >>> 2;
		if (t > (CW+1)'(64'sd1 <<< 30))       t = (CW+1)'(64'sd1 <<< 30);
		else if (t < -(CW+1)'(64'sd1 <<< 30)) t = -(CW+1)'(64'sd1 <<< 30);
		return QW'(t);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_out <= 1'b0;
		else         vld_out <= vld_s[N];
	end

	always_ff @(posedge clk) begin
		sc.cosv <= to_q30(x_s[N], neg_s[N]);
		sc.sinv <= to_q30(y_s[N], neg_s[N]);
	end

endmodule
`default_nettype wire

[src/erm_matrix.sv]
// Product and sum pipeline forming the nine rotation-matrix elements.
// Depends on erm_pkg.
`default_nettype none
module erm_matrix (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         vld_in,
	input  wire erm_pkg::sc_t sc_x,
	input  wire erm_pkg::sc_t sc_y,
	input  wire erm_pkg::sc_t sc_z,
	output logic              vld_out,
	output erm_pkg::res_t     res
);
	import erm_pkg::*;

	logic vld_s1, vld_s2;
	// first products
	logic signed [QW-1:0] sxsy_s1, cxsy_s1, cycz_s1, cxsz_s1, sxsz_s1, cysz_s1;
	logic signed [QW-1:0] cxcz_s1, sxcz_s1, sxcy_s1, cxcy_s1, cz_s1, sz_s1, sy_s1;
	// triple products and carried terms
	logic signed [QW-1:0] t1_s2, t2_s2, t4_s2, t5_s2;
	logic signed [QW-1:0] cycz_s2, cxsz_s2, sxsz_s2, cysz_s2, cxcz_s2, sxcz_s2;
	logic signed [QW-1:0] sxcy_s2, cxcy_s2, sy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_out <= 1'b0;
		end else begin
			vld_s1  <= vld_in;
			vld_s2  <= vld_s1;
			vld_out <= vld_s2;
		end
	end

	// pairwise products
	always_ff @(posedge clk) begin
		sxsy_s1 <= mul30(sc_x.sinv, sc_y.sinv);
		cxsy_s1 <= mul30(sc_x.cosv, sc_y.sinv);
		cycz_s1 <= mul30(sc_y.cosv, sc_z.cosv);
		cxsz_s1 <= mul30(sc_x.cosv, sc_z.sinv);
		sxsz_s1 <= mul30(sc_x.sinv, sc_z.sinv);
		cysz_s1 <= mul30(sc_y.cosv, sc_z.sinv);
		cxcz_s1 <= mul30(sc_x.cosv, sc_z.cosv);
		sxcz_s1 <= mul30(sc_x.sinv, sc_z.cosv);
		sxcy_s1 <= mul30(sc_x.sinv, sc_y.cosv);
		cxcy_s1 <= mul30(sc_x.cosv, sc_y.cosv);
		cz_s1   <= sc_z.cosv;
		sz_s1   <= sc_z.sinv;
		sy_s1   <= sc_y.sinv;
	end

	// triple products, left to right
	always_ff @(posedge clk) begin
		t1_s2   <= mul30(sxsy_s1, cz_s1);
		t2_s2   <= mul30(cxsy_s1, cz_s1);
		t4_s2   <= mul30(sxsy_s1, sz_s1);
		t5_s2   <= mul30(cxsy_s1, sz_s1);
		cycz_s2 <= cycz_s1;
		cxsz_s2 <= cxsz_s1;
		sxsz_s2 <= sxsz_s1;
		cysz_s2 <= cysz_s1;
		cxcz_s2 <= cxcz_s1;
		sxcz_s2 <= sxcz_s1;
		sxcy_s2 <= sxcy_s1;
		cxcy_s2 <= cxcy_s1;
		sy_s2   <= sy_s1;
	end

	// sums, rounding and saturation into the result register
	always_ff @(posedge clk) begin
		res.elem0 <= to_elem((QW+1)'(cycz_s2));
		res.elem1 <= to_elem((QW+1)'(cxsz_s2) + (QW+1)'(t1_s2));
		res.elem2 <= to_elem((QW+1)'(sxsz_s2) - (QW+1)'(t2_s2));
		res.elem3 <= to_elem(-(QW+1)'(cysz_s2));
		res.elem4 <= to_elem((QW+1)'(cxcz_s2) - (QW+1)'(t4_s2));
		res.elem5 <= to_elem((QW+1)'(sxcz_s2) + (QW+1)'(t5_s2));
		res.elem6 <= to_elem((QW+1)'(sy_s2));
		res.elem7 <= to_elem(-(QW+1)'(sxcy_s2));
		res.elem8 <= to_elem((QW+1)'(cxcy_s2));
	end

endmodule
`default_nettype wire

[src/euler_to_rotation_matrix.sv]
// Top level: Euler angles (x, y, z) to 3x3 rotation matrix, fully pipelined.
// Depends on erm_pkg, erm_cordic, erm_matrix.
//
//   channel  | handshake       | payload
//   ---------+-----------------+------------------------------
//   request  | start / busy    | req    (angle_x, angle_y, angle_z)
//   result   | done (strobe)   | result (elem0 .. elem8)
//
// A request is taken on every cycle with start high; busy is always low.
// The pipe holds a wrap and a quadrant-fold register, one register per CORDIC
// stage (16), a Q.30 rounding register, then product, triple product and sum registers.
// One result per cycle; done is high for one cycle per request.
// No stalls anywhere: the receiver cannot hold results off.
// arst_n clears the valid bits only; data registers carry no reset.
`default_nettype none
module euler_to_rotation_matrix (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire erm_pkg::req_t req,
	output logic               done,
	output erm_pkg::res_t      result
);
	import erm_pkg::*;

	logic vld_sc;
	sc_t  sc_x, sc_y, sc_z;

	// pipeline never stalls
	assign busy = 1'b0;

	// one sine/cosine pipe per axis, all of equal latency
	erm_cordic u_cordic_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (start),
		.angle   (req.angle_x),
		.vld_out (vld_sc),
		.sc      (sc_x)
	);

	erm_cordic u_cordic_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (start),
		.angle   (req.angle_y),
		.vld_out (),
		.sc      (sc_y)
	);

	erm_cordic u_cordic_z (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (start),
		.angle   (req.angle_z),
		.vld_out (),
		.sc      (sc_z)
	);

	// matrix products and output register
	erm_matrix u_matrix (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_sc),
		.sc_x    (sc_x),
		.sc_y    (sc_y),
		.sc_z    (sc_z),
		.vld_out (done),
		.res     (result)
	);

endmodule
`default_nettype wire

[tb/euler_to_rotation_matrix_tb.sv]
// Testbench for euler_to_rotation_matrix: drives angle triples, predicts the nine
// matrix elements with a local CORDIC and fixed-point model, and checks each result.
// Depends on erm_pkg and the euler_to_rotation_matrix RTL.
`default_nettype none
module euler_to_rotation_matrix_tb;
	import erm_pkg::*;

	localparam int LATENCY = 22;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	res_t result;

	res_t matrix_q[$];
	int   mismatch_cnt;

	longint atan_tab[32];
	longint gain;

	euler_to_rotation_matrix u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.result(result)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#(12 * 400000);
		$display("Mismatches found");
		$finish;
	end

	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_q32(longint v);
		return fshift(v + (64'sd1 <<< 27), 28);
	endfunction

	// arctangent table and gain, built from series and integer sqrt
	function automatic void build_consts();
		longint sum;
		longint unsigned p;
		longint unsigned v;
		longint unsigned r;
		longint unsigned b;
		atan_tab[0] = round_q32(64'sh3243F6A8885A308D >>> 2);
		for (int i = 1; i < 32; i++) begin
			sum = 0;
			for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
				p = 64'd1 << (60 - i * (2 * k + 1));
				if (k & 1) sum -= longint'(p / (2 * k + 1));
				else       sum += longint'(p / (2 * k + 1));
			end
			atan_tab[i] = round_q32(sum);
		end
		p = 64'd1 << 60;
		for (int i = 0; i < CORDIC_STAGES; i++) p += p >> (2 * i);
		v = p;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		if (r == 0) r = 1;
		gain = longint'((64'd1 << 62) / r);
	endfunction

	function automatic longint clamp_q30(longint v);
		v = fshift(v + 2, 2);
		if (v > (64'sd1 <<< 30)) v = 64'sd1 <<< 30;
		if (v < -(64'sd1 <<< 30)) v = -(64'sd1 <<< 30);
		return v;
	endfunction

	// cosine and sine of a raw angle, Q.30
	task automatic angle_sincos(input logic signed [ANGLE_BITS-1:0] raw,
		output longint c, output longint s);
		longint a, x, y, xn, pi_v, half_v;
		bit neg;
		pi_v = round_q32(64'sh3243F6A8885A308D);
		half_v = round_q32(64'sh3243F6A8885A308D >>> 1);
		a = longint'(raw) * (64'sd1 <<< (32 - ANGLE_FRAC));
		x = gain;
		y = 0;
		neg = 0;
		while (a > pi_v) a -= 2 * pi_v;
		while (a <= -pi_v) a += 2 * pi_v;
		if (a > half_v) begin
			a -= pi_v;
			neg = 1;
		end else if (a < -half_v) begin
			a += pi_v;
			neg = 1;
		end
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			if (a >= 0) begin
				xn = x - fshift(y, i);
				y = y + fshift(x, i);
				a -= atan_tab[i];
			end else begin
				xn = x + fshift(y, i);
				y = y - fshift(x, i);
				a += atan_tab[i];
			end
			x = xn;
		end
		if (neg) begin
			x = -x;
			y = -y;
		end
		c = clamp_q30(x);
		s = clamp_q30(y);
	endtask

	function automatic longint prod30(longint a, longint b);
		return fshift(a * b + (64'sd1 <<< 29), 30);
	endfunction

	function automatic logic [ELEMENT_BITS-1:0] elem_of(longint v);
		int sh;
		longint lim;
		sh = 30 - ELEM_FRAC;
		lim = 64'sd1 <<< ELEM_FRAC;
		if (sh > 0) v = fshift(v + (64'sd1 <<< (sh - 1)), sh);
		if (v > lim) v = lim;
		if (v < -lim) v = -lim;
		return v[ELEMENT_BITS-1:0];
	endfunction

	// expected rotation matrix for one request
	task automatic predict_matrix(input req_t r, output res_t m);
		longint cx, sx, cy, sy, cz, sz, sxsy, cxsy;
		angle_sincos(r.angle_x, cx, sx);
		angle_sincos(r.angle_y, cy, sy);
		angle_sincos(r.angle_z, cz, sz);
		sxsy = prod30(sx, sy);
		cxsy = prod30(cx, sy);
		m.elem0 = elem_of(prod30(cy, cz));
		m.elem1 = elem_of(prod30(cx, sz) + prod30(sxsy, cz));
		m.elem2 = elem_of(prod30(sx, sz) - prod30(cxsy, cz));
		m.elem3 = elem_of(-prod30(cy, sz));
		m.elem4 = elem_of(prod30(cx, cz) - prod30(sxsy, sz));
		m.elem5 = elem_of(prod30(sx, cz) + prod30(cxsy, sz));
		m.elem6 = elem_of(sy);
		m.elem7 = elem_of(-prod30(sx, cy));
		m.elem8 = elem_of(prod30(cx, cy));
	endtask

	task automatic report_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
		if (exp_v !== act_v) begin
			mismatch_cnt++;
			if (mismatch_cnt <= 10)
				$display("%0t %s: expected %0d got %0d", $time, name,
					$signed(exp_v), $signed(act_v));
		end
	endtask

	// result checker
	always @(posedge clk) begin
		res_t e;
		if (arst_n && done) begin
			if (matrix_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10) $display("%0t result with no request pending", $time);
			end else begin
				e = matrix_q.pop_front();
				report_field("elem0", e.elem0, result.elem0);
				report_field("elem1", e.elem1, result.elem1);
				report_field("elem2", e.elem2, result.elem2);
				report_field("elem3", e.elem3, result.elem3);
				report_field("elem4", e.elem4, result.elem4);
				report_field("elem5", e.elem5, result.elem5);
				report_field("elem6", e.elem6, result.elem6);
				report_field("elem7", e.elem7, result.elem7);
				report_field("elem8", e.elem8, result.elem8);
			end
		end
	end

	// random idle gap: mostly short, sometimes long, often none
	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) < 5) ? 0 :
			($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// send one request and wait for acceptance; start stays high for the next one
	task automatic send_request(input req_t r, input bit with_gaps);
		res_t m;
		if (with_gaps) idle_gap();
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_matrix(r, m);
		matrix_q = {matrix_q, m};
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		start <= 1'b0;
		while (matrix_q.size() != 0 && guard < 10000) begin
			@(posedge clk);
			guard++;
		end
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic req_t pack_req(int ax, int ay, int az);
		req_t r;
		r.angle_x = ax[15:0];
		r.angle_y = ay[15:0];
		r.angle_z = az[15:0];
		return r;
	endfunction

	// extremes, zeros, quadrant edges and wrap past +-pi
	task automatic test_directed();
		int v[12] = '{0, 1, -1, 32767, -32768, 6434, -6434, 6433, 12868, -12868, 3217, 25736};
		for (int i = 0; i < 12; i++) send_request(pack_req(v[i], v[(i + 4) % 12], v[(i + 7) % 12]), 0);
		send_request(pack_req(32767, 32767, 32767), 0);
		send_request(pack_req(-32768, -32768, -32768), 0);
		send_request(pack_req(0, 6434, 0), 0);
		send_request(pack_req(0, -6434, 0), 0);
		send_request(pack_req(16'h5555, 16'hAAAA, 16'h5555), 0);
		send_request(pack_req(16'hAAAA, 16'h5555, 16'hAAAA), 0);
	endtask

	// random angles over the full range, back to back and with gaps
	task automatic test_random(int count);
		req_t r;
		logic [63:0] rnd;
		for (int i = 0; i < count; i++) begin
			rnd = {$urandom(), $urandom()};
			r = rnd[47:0];
			if ($urandom_range(0, 3) == 0)
				r.angle_y = ANGLE_BITS'(int'($urandom_range(0, 12868)) - 6434);
			send_request(r, (i / 200) % 2 == 1);
		end
	endtask

	initial begin
		mismatch_cnt = 0;
		build_consts();
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		drain();
		test_random(650);
		// hold off until the pipeline is empty
		drain();
		test_random(650);
		drain();
		// requests that never produced a result
		if (matrix_q.size() != 0) begin
			mismatch_cnt += matrix_q.size();
			$display("%0d results missing", matrix_q.size());
		end
		if (mismatch_cnt == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
`default_nettype wire

[euler_to_rotation_matrix.f]
src/erm_pkg.sv
src/erm_cordic.sv
src/erm_matrix.sv
src/euler_to_rotation_matrix.sv
tb/euler_to_rotation_matrix_tb.sv
